### sv/esfm_pkg.sv
package esfm_pkg;

	localparam int unsigned AddrWidth = 5;
	localparam int unsigned DataWidth = 32;

	localparam int unsigned PosWidth  = 16;
	localparam int unsigned PctWidth  = 7;
	localparam int unsigned DutyWidth = 8;
	localparam int unsigned CurWidth  = 16;
	localparam int unsigned LoadWidth = 16;
	localparam int unsigned CodeWidth = 4;
	localparam int unsigned CntWidth  = 16;

	localparam logic [PosWidth-1:0]  OvertravelLimitRst  = 16'd1005;
	localparam logic [PctWidth-1:0]  DoorOpenLimitRst    = 7'd5;
	localparam logic [CurWidth-1:0]  OvercurrentLimitRst = 16'd15000;
	localparam logic [CntWidth-1:0]  OvercurrentTicksRst = 16'd50;
	localparam logic [LoadWidth-1:0] OverloadSetRst      = 16'd900;
	localparam logic [LoadWidth-1:0] OverloadClearRst    = 16'd850;

	typedef enum logic [2:0] {
		REG_OVERTRAVEL_LIMIT  = 3'd0,
		REG_DOOR_OPEN_LIMIT   = 3'd1,
		REG_OVERCURRENT_LIMIT = 3'd2,
		REG_OVERCURRENT_TICKS = 3'd3,
		REG_OVERLOAD_SET      = 3'd4,
		REG_OVERLOAD_CLEAR    = 3'd5
	} reg_idx_t;

	localparam logic [CodeWidth-1:0] ST_IDLE      = 4'd2;
	localparam logic [CodeWidth-1:0] ST_DOOR_OPEN = 4'd4;
	localparam logic [CodeWidth-1:0] ST_OVERLOAD  = 4'd11;
	localparam logic [CodeWidth-1:0] ST_FAULT     = 4'd14;
	localparam logic [CodeWidth-1:0] ST_ESTOP     = 4'd15;

	localparam logic [CodeWidth-1:0] FC_NONE        = 4'd0;
	localparam logic [CodeWidth-1:0] FC_ESTOP       = 4'd1;
	localparam logic [CodeWidth-1:0] FC_OVERTRAVEL  = 4'd2;
	localparam logic [CodeWidth-1:0] FC_OVERCURRENT = 4'd5;
	localparam logic [CodeWidth-1:0] FC_DOOR_JAM    = 4'd8;

endpackage

### sv/elevator_safety_fault_monitor.sv
// Elevator safety fault monitor. Each input transaction is one evaluation tick carrying the
// sensor readings and the current car state and fault code; each tick yields exactly one
// result transaction with the new state, fault code, overload flag and safety-active bit.
// Checks run in priority order: emergency stop, overtravel, door open while the hoist is
// driven, then overcurrent persisting for the configured number of ticks (counter saturates
// at 65535, cleared when current is back within limit). Otherwise the overload flag follows
// set/clear hysteresis. Throughput is one tick per cycle while the result is not stalled.
// A tick is captured in the input register at acceptance, and its result moves into the result
// register once that register is free or not stalled, raising out_valid; the single decision stage
// between the two registers also updates the persistence counter and overload flag. The input stalls only
// while both registers are full and the result is stalled. Thresholds are written over
// the APB port at byte addresses 0x00..0x14 and should only change while the block is idle.
module elevator_safety_fault_monitor
	import esfm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [DataWidth-1:0] pwdata,
	output logic [DataWidth-1:0] prdata,
	output logic                 pready,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 estop,
	input  logic [PosWidth-1:0]  position_cm,
	input  logic [PctWidth-1:0]  door_pct,
	input  logic [DutyWidth-1:0] hoist_duty,
	input  logic [CurWidth-1:0]  current_ma,
	input  logic [LoadWidth-1:0] load_kg,
	input  logic [CodeWidth-1:0] car_state_in,
	input  logic [CodeWidth-1:0] fault_in,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CodeWidth-1:0] car_state_out,
	output logic [CodeWidth-1:0] fault_out,
	output logic                 overload_flag,
	output logic                 safety_active
);

	logic [PosWidth-1:0]  overtravel_limit_q;
	logic [PctWidth-1:0]  door_open_limit_q;
	logic [CurWidth-1:0]  overcurrent_limit_q;
	logic [CntWidth-1:0]  oc_persist_q;
	logic [LoadWidth-1:0] overload_set_q;
	logic [LoadWidth-1:0] overload_clear_q;

	logic [CntWidth-1:0]  oc_count_q;
	logic                 overload_held_q;

	logic                 valid_s1;
	logic                 estop_s1;
	logic [PosWidth-1:0]  pos_s1;
	logic [PctWidth-1:0]  door_s1;
	logic [DutyWidth-1:0] duty_s1;
	logic [CurWidth-1:0]  cur_s1;
	logic [LoadWidth-1:0] load_s1;
	logic [CodeWidth-1:0] st_s1;
	logic [CodeWidth-1:0] flt_s1;

	logic                 valid_s2;
	logic [CodeWidth-1:0] st_s2;
	logic [CodeWidth-1:0] flt_s2;
	logic                 ovl_s2;
	logic                 safe_s2;

	logic                 cfg_wr;
	reg_idx_t             cfg_idx;
	logic                 adv_s1;
	logic                 acc_in;

	logic [CntWidth-1:0]  oc_count_d;
	logic                 overload_held_d;
	logic [CodeWidth-1:0] st_d;
	logic [CodeWidth-1:0] flt_d;
	logic                 safe_d;
	logic [CntWidth-1:0]  oc_inc;
	logic                 done;

	// config port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[AddrWidth-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overtravel_limit_q  <= OvertravelLimitRst;
			door_open_limit_q   <= DoorOpenLimitRst;
			overcurrent_limit_q <= OvercurrentLimitRst;
			oc_persist_q        <= OvercurrentTicksRst;
			overload_set_q      <= OverloadSetRst;
			overload_clear_q    <= OverloadClearRst;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_OVERTRAVEL_LIMIT:  overtravel_limit_q  <= pwdata[PosWidth-1:0];
				REG_DOOR_OPEN_LIMIT:   door_open_limit_q   <= pwdata[PctWidth-1:0];
				REG_OVERCURRENT_LIMIT: overcurrent_limit_q <= pwdata[CurWidth-1:0];
				REG_OVERCURRENT_TICKS: oc_persist_q        <= pwdata[CntWidth-1:0];
				REG_OVERLOAD_SET:      overload_set_q      <= pwdata[LoadWidth-1:0];
				REG_OVERLOAD_CLEAR:    overload_clear_q    <= pwdata[LoadWidth-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_OVERTRAVEL_LIMIT:  prdata = DataWidth'(overtravel_limit_q);
			REG_DOOR_OPEN_LIMIT:   prdata = DataWidth'(door_open_limit_q);
			REG_OVERCURRENT_LIMIT: prdata = DataWidth'(overcurrent_limit_q);
			REG_OVERCURRENT_TICKS: prdata = DataWidth'(oc_persist_q);
			REG_OVERLOAD_SET:      prdata = DataWidth'(overload_set_q);
			REG_OVERLOAD_CLEAR:    prdata = DataWidth'(overload_clear_q);
			default:               prdata = '0;
		endcase
	end

	// pipeline control
	assign adv_s1   = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~adv_s1;
	assign acc_in   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			estop_s1 <= estop;
			pos_s1   <= position_cm;
			door_s1  <= door_pct;
			duty_s1  <= hoist_duty;
			cur_s1   <= current_ma;
			load_s1  <= load_kg;
			st_s1    <= car_state_in;
			flt_s1   <= fault_in;
		end
	end

	// decision logic
	assign oc_inc = (oc_count_q != {CntWidth{1'b1}}) ? oc_count_q + 1'b1 : oc_count_q;

	always_comb begin
		st_d            = st_s1;
		flt_d           = flt_s1;
		oc_count_d      = oc_count_q;
		overload_held_d = overload_held_q;
		done            = 1'b0;
		if (estop_s1) begin
			flt_d = FC_ESTOP;
			st_d  = ST_ESTOP;
			done  = 1'b1;
		end else if (pos_s1 > overtravel_limit_q) begin
			flt_d = FC_OVERTRAVEL;
			st_d  = ST_FAULT;
			done  = 1'b1;
		end else if ((door_s1 > door_open_limit_q) && (duty_s1 != '0)) begin
			flt_d = FC_DOOR_JAM;
			st_d  = ST_FAULT;
			done  = 1'b1;
		end else if (cur_s1 > overcurrent_limit_q) begin
			oc_count_d = oc_inc;
			if (oc_inc >= oc_persist_q) begin
				flt_d = FC_OVERCURRENT;
				st_d  = ST_FAULT;
				done  = 1'b1;
			end
		end else begin
			oc_count_d = '0;
		end

		if (!done) begin
			if (load_s1 > overload_set_q) begin
				overload_held_d = 1'b1;
				if (st_s1 inside {ST_IDLE, ST_DOOR_OPEN}) begin
					st_d = ST_OVERLOAD;
				end
			end else if (overload_held_q && (load_s1 < overload_clear_q)) begin
				overload_held_d = 1'b0;
			end
		end

		safe_d = estop_s1 | (flt_d != FC_NONE) | (st_d == ST_FAULT) | (st_d == ST_ESTOP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_count_q      <= '0;
			overload_held_q <= 1'b0;
			valid_s2        <= 1'b0;
		end else begin
			if (adv_s1) begin
				oc_count_q      <= oc_count_d;
				overload_held_q <= overload_held_d;
				valid_s2        <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			st_s2   <= st_d;
			flt_s2  <= flt_d;
			ovl_s2  <= overload_held_d;
			safe_s2 <= safe_d;
		end
	end

	assign out_valid     = valid_s2;
	assign car_state_out = st_s2;
	assign fault_out     = flt_s2;
	assign overload_flag = ovl_s2;
	assign safety_active = safe_s2;

endmodule

### sv/esfm_checker.sv
module esfm_checker
	import esfm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [CodeWidth-1:0] car_state_out,
	input logic [CodeWidth-1:0] fault_out,
	input logic                 overload_flag,
	input logic                 safety_active
);

	// input backs up only behind a full, stalled result
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while result path free");

	a_safe_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !safety_active |->
			fault_out == FC_NONE && car_state_out != ST_FAULT && car_state_out != ST_ESTOP)
		else $error("safety_active low with fault or fault state");

	a_fault_safe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fault_out != FC_NONE || car_state_out == ST_FAULT ||
			car_state_out == ST_ESTOP) |-> safety_active)
		else $error("safety_active missing");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(car_state_out) &&
			$stable(fault_out) && $stable(overload_flag) && $stable(safety_active))
		else $error("stalled result changed");

endmodule

bind elevator_safety_fault_monitor esfm_checker u_esfm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.car_state_out (car_state_out),
	.fault_out     (fault_out),
	.overload_flag (overload_flag),
	.safety_active (safety_active)
);

### verif/tb_elevator_safety_fault_monitor.sv
module tb_elevator_safety_fault_monitor;
	import esfm_pkg::*;

	localparam int unsigned CycleLimit = 250000;
	localparam int unsigned PrintCap   = 100;

	typedef struct packed {
		logic                 estop;
		logic [PosWidth-1:0]  position_cm;
		logic [PctWidth-1:0]  door_pct;
		logic [DutyWidth-1:0] hoist_duty;
		logic [CurWidth-1:0]  current_ma;
		logic [LoadWidth-1:0] load_kg;
		logic [CodeWidth-1:0] car_state;
		logic [CodeWidth-1:0] fault;
	} tick_t;

	typedef struct packed {
		logic [CodeWidth-1:0] car_state;
		logic [CodeWidth-1:0] fault;
		logic                 overload;
		logic                 safety;
	} verdict_t;

	typedef struct packed {
		tick_t    tick;
		logic     typed;
		verdict_t want;
	} directed_row_t;

	typedef enum {PACE_FULL, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH} pace_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [AddrWidth-1:0] paddr = '0;
	logic [DataWidth-1:0] pwdata = '0;
	logic [DataWidth-1:0] prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 estop = 1'b0;
	logic [PosWidth-1:0]  position_cm = '0;
	logic [PctWidth-1:0]  door_pct = '0;
	logic [DutyWidth-1:0] hoist_duty = '0;
	logic [CurWidth-1:0]  current_ma = '0;
	logic [LoadWidth-1:0] load_kg = '0;
	logic [CodeWidth-1:0] car_state_in = '0;
	logic [CodeWidth-1:0] fault_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CodeWidth-1:0] car_state_out;
	logic [CodeWidth-1:0] fault_out;
	logic                 overload_flag;
	logic                 safety_active;

	// shadow thresholds
	logic [PosWidth-1:0]  lim_overtravel = OvertravelLimitRst;
	logic [PctWidth-1:0]  lim_door       = DoorOpenLimitRst;
	logic [CurWidth-1:0]  lim_current    = OvercurrentLimitRst;
	logic [CntWidth-1:0]  lim_ticks      = OvercurrentTicksRst;
	logic [LoadWidth-1:0] lim_ovl_set    = OverloadSetRst;
	logic [LoadWidth-1:0] lim_ovl_clear  = OverloadClearRst;

	// shadow monitor state
	logic [CntWidth-1:0]  oc_count = '0;
	logic                 ovl_held = 1'b0;

	verdict_t    verdict_q[$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned sender_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned surge_left = 0;

	directed_row_t directed_rows [23] = '{
		'{'{1'b0, 16'd0, 7'd0, 8'd0, 16'd0, 16'd0, 4'd0, FC_NONE}, 1'b1,
			'{4'd0, FC_NONE, 1'b0, 1'b0}},
		'{'{1'b1, 16'd65535, 7'd100, 8'd255, 16'd65535, 16'd65535, ST_IDLE, FC_NONE}, 1'b1,
			'{ST_ESTOP, FC_ESTOP, 1'b0, 1'b1}},
		'{'{1'b0, 16'd1006, 7'd0, 8'd0, 16'd0, 16'd0, ST_IDLE, FC_NONE}, 1'b1,
			'{ST_FAULT, FC_OVERTRAVEL, 1'b0, 1'b1}},
		'{'{1'b0, 16'd1005, 7'd0, 8'd0, 16'd0, 16'd0, ST_IDLE, FC_NONE}, 1'b1,
			'{ST_IDLE, FC_NONE, 1'b0, 1'b0}},
		'{'{1'b0, 16'd0, 7'd6, 8'd1, 16'd0, 16'd0, ST_IDLE, FC_NONE}, 1'b1,
			'{ST_FAULT, FC_DOOR_JAM, 1'b0, 1'b1}},
		'{'{1'b0, 16'd0, 7'd100, 8'd0, 16'd0, 16'd0, ST_DOOR_OPEN, FC_NONE}, 1'b1,
			'{ST_DOOR_OPEN, FC_NONE, 1'b0, 1'b0}},
		'{'{1'b0, 16'd0, 7'd5, 8'd255, 16'd0, 16'd0, ST_IDLE, FC_NONE}, 1'b1,
			'{ST_IDLE, FC_NONE, 1'b0, 1'b0}},
		'{'{1'b0, 16'd500, 7'd0, 8'd128, 16'd15001, 16'd0, ST_IDLE, FC_NONE}, 1'b0, '0},
		'{'{1'b0, 16'd500, 7'd0, 8'd128, 16'd15001, 16'd0, ST_IDLE, FC_NONE}, 1'b0, '0},
		'{'{1'b0, 16'd500, 7'd3, 8'd128, 16'd15000, 16'd0, ST_IDLE, FC_NONE}, 1'b0, '0},
		'{'{1'b0, 16'd0, 7'd0, 8'd0, 16'd0, 16'd900, ST_IDLE, FC_NONE}, 1'b1,
			'{ST_IDLE, FC_NONE, 1'b0, 1'b0}},
		'{'{1'b0, 16'd0, 7'd0, 8'd0, 16'd0, 16'd901, ST_IDLE, FC_NONE}, 1'b0, '0},
		'{'{1'b0, 16'd0, 7'd0, 8'd0, 16'd0, 16'd850, ST_DOOR_OPEN, FC_NONE}, 1'b0, '0},
		'{'{1'b0, 16'd0, 7'd0, 8'd0, 16'd0, 16'd849, ST_DOOR_OPEN, FC_NONE}, 1'b0, '0},
		'{'{1'b0, 16'd0, 7'd0, 8'd0, 16'd0, 16'd65535, ST_DOOR_OPEN, FC_NONE}, 1'b0, '0},
		'{'{1'b1, 16'd0, 7'd0, 8'd0, 16'd0, 16'd0, ST_OVERLOAD, FC_NONE}, 1'b0, '0},
		'{'{1'b0, 16'd2000, 7'd0, 8'd0, 16'd0, 16'd0, ST_OVERLOAD, FC_NONE}, 1'b0, '0},
		'{'{1'b0, 16'd0, 7'd0, 8'd0, 16'd0, 16'd0, ST_OVERLOAD, FC_NONE}, 1'b0, '0},
		'{'{1'b0, 16'd0, 7'd0, 8'd0, 16'd0, 16'd0, 4'd7, 4'd3}, 1'b1,
			'{4'd7, 4'd3, 1'b0, 1'b1}},
		'{'{1'b0, 16'd0, 7'd0, 8'd0, 16'd0, 16'd0, ST_FAULT, FC_NONE}, 1'b1,
			'{ST_FAULT, FC_NONE, 1'b0, 1'b1}},
		'{'{1'b0, 16'd0, 7'd0, 8'd0, 16'd0, 16'd0, ST_ESTOP, 4'd15}, 1'b1,
			'{ST_ESTOP, 4'd15, 1'b0, 1'b1}},
		'{'{1'b0, 16'd0, 7'd0, 8'd0, 16'd0, 16'd1000, ST_ESTOP, FC_NONE}, 1'b0, '0},
		'{'{1'b0, 16'd1005, 7'd5, 8'd255, 16'd65535, 16'd0, ST_IDLE, FC_NONE}, 1'b0, '0}
	};

	elevator_safety_fault_monitor u_top (.*);

	always #10 clk = ~clk;

	function automatic verdict_t judge_tick(input tick_t t);
		verdict_t v;
		logic     ended;
		v.car_state = t.car_state;
		v.fault = t.fault;
		ended = 1'b0;
		if (t.estop) begin
			v.fault = FC_ESTOP;
			v.car_state = ST_ESTOP;
			ended = 1'b1;
		end else if (t.position_cm > lim_overtravel) begin
			v.fault = FC_OVERTRAVEL;
			v.car_state = ST_FAULT;
			ended = 1'b1;
		end else if (t.door_pct > lim_door && t.hoist_duty != '0) begin
			v.fault = FC_DOOR_JAM;
			v.car_state = ST_FAULT;
			ended = 1'b1;
		end else if (t.current_ma > lim_current) begin
			if (oc_count != '1)
				oc_count = oc_count + 1'b1;
			if (oc_count >= lim_ticks) begin
				v.fault = FC_OVERCURRENT;
				v.car_state = ST_FAULT;
				ended = 1'b1;
			end
		end else begin
			oc_count = '0;
		end
		if (!ended) begin
			if (t.load_kg > lim_ovl_set) begin
				ovl_held = 1'b1;
				if (v.car_state == ST_IDLE || v.car_state == ST_DOOR_OPEN)
					v.car_state = ST_OVERLOAD;
			end else if (ovl_held && t.load_kg < lim_ovl_clear) begin
				ovl_held = 1'b0;
			end
		end
		v.overload = ovl_held;
		v.safety = t.estop || v.fault != FC_NONE || v.car_state == ST_FAULT ||
			v.car_state == ST_ESTOP;
		return v;
	endfunction

	function automatic int nudge(int center, int top);
		int v;
		v = center + int'($urandom_range(2)) - 1;
		if (v < 0)
			v = 0;
		if (v > top)
			v = top;
		return v;
	endfunction

	function automatic tick_t roll_tick();
		tick_t       t;
		int unsigned span;
		t = '0;
		if ($urandom_range(99) < 10) begin
			// noise
			t.estop = 1'($urandom_range(1));
			t.position_cm = 16'($urandom);
			t.door_pct = 7'($urandom_range(100));
			t.hoist_duty = 8'($urandom);
			t.current_ma = 16'($urandom);
			t.load_kg = 16'($urandom);
			t.car_state = 4'($urandom);
			t.fault = 4'($urandom);
		end else begin
			t.estop = ($urandom_range(99) < 4);
			if ($urandom_range(99) < 8)
				t.position_cm = 16'(nudge(int'(lim_overtravel), 65535));
			else
				t.position_cm = 16'($urandom_range(lim_overtravel));
			if ($urandom_range(1)) begin
				// hoist running, door normally shut
				t.hoist_duty = 8'($urandom_range(255, 1));
				if ($urandom_range(99) < 10)
					t.door_pct = 7'(nudge(int'(lim_door), 100));
				else
					t.door_pct = 7'($urandom_range(lim_door > 100 ? 100 : lim_door));
			end else begin
				t.hoist_duty = '0;
				t.door_pct = 7'($urandom_range(100));
			end
			if (surge_left == 0 && $urandom_range(99) < 12) begin
				span = (lim_ticks > 10) ? 12 : int'(lim_ticks) + 2;
				surge_left = $urandom_range(span, 1);
			end
			if (surge_left > 0) begin
				surge_left--;
				t.current_ma = (lim_current == '1) ? '1 :
					16'($urandom_range(65535, int'(lim_current) + 1));
			end else if ($urandom_range(99) < 15) begin
				t.current_ma = 16'(nudge(int'(lim_current), 65535));
			end else begin
				t.current_ma = 16'($urandom_range(lim_current));
			end
			case ($urandom_range(2))
				0: t.load_kg = 16'(nudge(int'(lim_ovl_set), 65535));
				1: t.load_kg = 16'(nudge(int'(lim_ovl_clear), 65535));
				default: t.load_kg = 16'($urandom);
			endcase
			if ($urandom_range(99) < 75) begin
				case ($urandom_range(4))
					0: t.car_state = ST_IDLE;
					1: t.car_state = ST_DOOR_OPEN;
					2: t.car_state = ST_OVERLOAD;
					3: t.car_state = ST_FAULT;
					default: t.car_state = ST_ESTOP;
				endcase
			end else begin
				t.car_state = 4'($urandom);
			end
			if ($urandom_range(99) < 60) begin
				t.fault = FC_NONE;
			end else if ($urandom_range(99) < 60) begin
				case ($urandom_range(3))
					0: t.fault = FC_ESTOP;
					1: t.fault = FC_OVERTRAVEL;
					2: t.fault = FC_OVERCURRENT;
					default: t.fault = FC_DOOR_JAM;
				endcase
			end else begin
				t.fault = 4'($urandom);
			end
		end
		return t;
	endfunction

	function automatic void set_pace(pace_t p);
		case (p)
			PACE_SENDER_GAPS: begin
				sender_pct = 58;
				stall_pct = 0;
			end
			PACE_RECEIVER_STALLS: begin
				sender_pct = 0;
				stall_pct = 58;
			end
			PACE_BOTH: begin
				sender_pct = 22;
				stall_pct = 22;
			end
			default: begin
				sender_pct = 0;
				stall_pct = 0;
			end
		endcase
	endfunction

	task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
		if (mismatches < PrintCap)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic send_tick(tick_t t, logic typed, verdict_t want);
		verdict_t v;
		while (sender_pct != 0 && $urandom_range(99) < sender_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		estop <= t.estop;
		position_cm <= t.position_cm;
		door_pct <= t.door_pct;
		hoist_duty <= t.hoist_duty;
		current_ma <= t.current_ma;
		load_kg <= t.load_kg;
		car_state_in <= t.car_state;
		fault_in <= t.fault;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		v = judge_tick(t);
		if (typed)
			v = want;
		verdict_q.push_back(v);
	endtask

	task automatic drain(int unsigned extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic set_register(reg_idx_t idx, int unsigned val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= DataWidth'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_OVERTRAVEL_LIMIT:  lim_overtravel = PosWidth'(val);
			REG_DOOR_OPEN_LIMIT:   lim_door = PctWidth'(val);
			REG_OVERCURRENT_LIMIT: lim_current = CurWidth'(val);
			REG_OVERCURRENT_TICKS: lim_ticks = CntWidth'(val);
			REG_OVERLOAD_SET:      lim_ovl_set = LoadWidth'(val);
			REG_OVERLOAD_CLEAR:    lim_ovl_clear = LoadWidth'(val);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_limits(int unsigned ovt, int unsigned door, int unsigned cur,
			int unsigned ticks, int unsigned ovl_set, int unsigned ovl_clear);
		drain(4);
		set_register(REG_OVERTRAVEL_LIMIT, ovt);
		set_register(REG_DOOR_OPEN_LIMIT, door);
		set_register(REG_OVERCURRENT_LIMIT, cur);
		set_register(REG_OVERCURRENT_TICKS, ticks);
		set_register(REG_OVERLOAD_SET, ovl_set);
		set_register(REG_OVERLOAD_CLEAR, ovl_clear);
	endtask

	task automatic random_limits(logic clear_above_set);
		int unsigned ovl_set;
		int unsigned ovl_clear;
		ovl_set = $urandom_range(1500, 100);
		if (clear_above_set)
			ovl_clear = ovl_set + $urandom_range(200, 1);
		else
			ovl_clear = ovl_set - $urandom_range(100);
		set_limits($urandom_range(2000, 300), $urandom_range(100), $urandom_range(20000, 500),
			$urandom_range(6, 1), ovl_set, ovl_clear);
	endtask

	task automatic run_random(int unsigned count, pace_t pace, logic hold_mid);
		set_pace(pace);
		for (int unsigned i = 0; i < count; i++) begin
			if (hold_mid && i == count / 2)
				drain(0);
			send_tick(roll_tick(), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		verdict_t want;
		if (out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				flag_mismatch("result with none pending", 1, 0);
			end else begin
				want = verdict_q.pop_front();
				if (car_state_out !== want.car_state)
					flag_mismatch("car_state_out", car_state_out, want.car_state);
				if (fault_out !== want.fault)
					flag_mismatch("fault_out", fault_out, want.fault);
				if (overload_flag !== want.overload)
					flag_mismatch("overload_flag", overload_flag, want.overload);
				if (safety_active !== want.safety)
					flag_mismatch("safety_active", safety_active, want.safety);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		tick_t sat_tick;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_pace(PACE_FULL);
		foreach (directed_rows[i])
			send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);
		run_random(190, PACE_SENDER_GAPS, 1'b0);

		// zero thresholds: first overcurrent tick faults
		set_limits(0, 0, 0, 0, 0, 0);
		run_random(190, PACE_RECEIVER_STALLS, 1'b0);

		set_limits(65535, 127, 65535, 65535, 65535, 65535);
		run_random(100, PACE_BOTH, 1'b0);

		random_limits(1'b0);
		run_random(200, PACE_FULL, 1'b0);
		random_limits(1'b1);
		run_random(200, PACE_RECEIVER_STALLS, 1'b1);
		random_limits(1'b0);
		run_random(200, PACE_BOTH, 1'b0);
		random_limits(1'b1);
		run_random(200, PACE_SENDER_GAPS, 1'b0);
		random_limits(1'b0);
		run_random(150, PACE_RECEIVER_STALLS, 1'b0);

		// long overcurrent run below the persistence setting
		set_limits(65535, 100, 0, 65535, 65535, 0);
		set_pace(PACE_FULL);
		for (int i = 0; i < 100; i++) begin
			sat_tick = '0;
			sat_tick.position_cm = 16'($urandom);
			sat_tick.door_pct = 7'($urandom_range(100));
			sat_tick.current_ma = (i == 0) ? '0 : 16'($urandom_range(65535, 1));
			sat_tick.load_kg = 16'($urandom);
			sat_tick.car_state = 4'($urandom);
			send_tick(sat_tick, 1'b0, '0);
		end

		drain(10);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
sv/esfm_pkg.sv
sv/elevator_safety_fault_monitor.sv
sv/esfm_checker.sv
verif/tb_elevator_safety_fault_monitor.sv
